### hw/rtl/etl_pkg.sv
// Shared constants and types for the exception table lookup block.
package etl_pkg;

   localparam int TABLE_DEPTH  = 256;
   localparam int ADDR_WIDTH   = $clog2(TABLE_DEPTH);
   localparam int COUNT_WIDTH  = $clog2(TABLE_DEPTH + 1);
   localparam int ENTRY_WIDTH  = 64;
   localparam int WORD_WIDTH   = 32;
   localparam int OFFSET_WIDTH = 30;
   localparam int INDEX_WIDTH  = 8;
   localparam int CSR_WIDTH    = 9;

   localparam logic REQ_WRITE  = 1'b0;
   localparam logic REQ_LOOKUP = 1'b1;

   typedef struct packed {
      logic start;
      logic write;
      logic issue;
      logic load_rsp;
   } ctrl_cmd_type;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] entry_total;
   } dp_status_type;

endpackage

### hw/rtl/etl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module etl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/etl_datapath.sv
// Datapath: entry table, count register, scan evaluation and result registers.
module etl_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  etl_pkg::ctrl_cmd_type               cmd,
   output etl_pkg::dp_status_type              status,
   input  logic [etl_pkg::ADDR_WIDTH-1:0]      rd_index,
   input  logic                                csr_we,
   input  logic [etl_pkg::CSR_WIDTH-1:0]       csr_wdata,
   input  logic [etl_pkg::INDEX_WIDTH-1:0]     req_entry_index,
   input  logic [etl_pkg::WORD_WIDTH-1:0]      req_entry_insn,
   input  logic [etl_pkg::WORD_WIDTH-1:0]      req_entry_fixup,
   input  logic [etl_pkg::WORD_WIDTH-1:0]      req_lookup_addr,
   output logic                                rsp_found,
   output logic [etl_pkg::WORD_WIDTH-1:0]      rsp_fixup_addr,
   output logic [etl_pkg::OFFSET_WIDTH-1:0]    rsp_range_offset,
   output logic                                rsp_offset_valid
);
   import etl_pkg::*;

   logic [CSR_WIDTH-1:0]    count_ff;
   logic [CSR_WIDTH-1:0]    count_in;
   logic                    eval_ff;
   logic                    eval_in;
   logic [WORD_WIDTH-1:0]   addr_ff;
   logic [WORD_WIDTH-1:0]   addr_in;
   logic                    pair_ff;
   logic                    pair_in;
   logic [WORD_WIDTH-1:0]   start_ff;
   logic [WORD_WIDTH-1:0]   start_in;
   logic                    exact_hit_ff;
   logic                    exact_hit_in;
   logic [WORD_WIDTH-1:0]   exact_fix_ff;
   logic [WORD_WIDTH-1:0]   exact_fix_in;
   logic                    range_hit_ff;
   logic                    range_hit_in;
   logic [WORD_WIDTH-1:0]   range_fix_ff;
   logic [WORD_WIDTH-1:0]   range_fix_in;
   logic [OFFSET_WIDTH-1:0] range_off_ff;
   logic [OFFSET_WIDTH-1:0] range_off_in;
   logic                    found_ff;
   logic                    found_in;
   logic [WORD_WIDTH-1:0]   fixup_ff;
   logic [WORD_WIDTH-1:0]   fixup_in;
   logic [OFFSET_WIDTH-1:0] offset_ff;
   logic [OFFSET_WIDTH-1:0] offset_in;
   logic                    off_valid_ff;
   logic                    off_valid_in;
   logic                    wr_en;
   logic [ENTRY_WIDTH-1:0]  rd_data;
   logic [WORD_WIDTH-1:0]   ent_insn;
   logic [WORD_WIDTH-1:0]   ent_fixup;
   logic [WORD_WIDTH-1:0]   span;

   assign wr_en = cmd.write && (32'(req_entry_index) < TABLE_DEPTH);

   etl_ram #(
      .WIDTH(ENTRY_WIDTH),
      .DEPTH(TABLE_DEPTH)
   ) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(ADDR_WIDTH'(req_entry_index)),
      .wr_data({req_entry_insn, req_entry_fixup}),
      .rd_en  (cmd.issue),
      .rd_addr(rd_index),
      .rd_data(rd_data)
   );

   assign ent_insn  = rd_data[ENTRY_WIDTH-1:WORD_WIDTH];
   assign ent_fixup = rd_data[WORD_WIDTH-1:0];
   assign span      = addr_ff - start_ff;

   always_comb begin
      if (32'(count_ff) > TABLE_DEPTH) begin
         status.entry_total = COUNT_WIDTH'(TABLE_DEPTH);
      end else begin
         status.entry_total = COUNT_WIDTH'(count_ff);
      end
   end

   always_comb begin
      count_in     = csr_we ? csr_wdata : count_ff;
      eval_in      = cmd.issue;
      addr_in      = addr_ff;
      pair_in      = pair_ff;
      start_in     = start_ff;
      exact_hit_in = exact_hit_ff;
      exact_fix_in = exact_fix_ff;
      range_hit_in = range_hit_ff;
      range_fix_in = range_fix_ff;
      range_off_in = range_off_ff;
      if (cmd.start) begin
         addr_in      = req_lookup_addr;
         pair_in      = 1'b0;
         exact_hit_in = 1'b0;
         range_hit_in = 1'b0;
      end else if (eval_ff) begin
         if (pair_ff) begin
            // Second word of a range pair closes the range.
            pair_in = 1'b0;
            if (!range_hit_ff && (start_ff <= addr_ff) && (ent_insn > addr_ff)) begin
               range_hit_in = 1'b1;
               range_fix_in = ent_fixup;
               range_off_in = span[WORD_WIDTH-1:2];
            end
         end else if (ent_fixup == '0) begin
            pair_in  = 1'b1;
            start_in = ent_insn;
         end else if (!exact_hit_ff && (ent_insn == addr_ff)) begin
            exact_hit_in = 1'b1;
            exact_fix_in = ent_fixup;
         end
      end
   end

   always_comb begin
      found_in     = found_ff;
      fixup_in     = fixup_ff;
      offset_in    = offset_ff;
      off_valid_in = off_valid_ff;
      if (cmd.load_rsp) begin
         found_in     = exact_hit_ff || range_hit_ff;
         off_valid_in = !exact_hit_ff && range_hit_ff;
         if (exact_hit_ff) begin
            fixup_in  = exact_fix_ff;
            offset_in = '0;
         end else if (range_hit_ff) begin
            fixup_in  = range_fix_ff;
            offset_in = range_off_ff;
         end else begin
            fixup_in  = '0;
            offset_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         eval_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         eval_ff  <= eval_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      pair_ff      <= pair_in;
      start_ff     <= start_in;
      exact_hit_ff <= exact_hit_in;
      exact_fix_ff <= exact_fix_in;
      range_hit_ff <= range_hit_in;
      range_fix_ff <= range_fix_in;
      range_off_ff <= range_off_in;
      found_ff     <= found_in;
      fixup_ff     <= fixup_in;
      offset_ff    <= offset_in;
      off_valid_ff <= off_valid_in;
   end

   assign rsp_found        = found_ff;
   assign rsp_fixup_addr   = fixup_ff;
   assign rsp_range_offset = offset_ff;
   assign rsp_offset_valid = off_valid_ff;

endmodule

### hw/rtl/etl_ctrl.sv
// Controller: request handshake, table scan sequencing and response handshake.
module etl_ctrl (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_type,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   input  etl_pkg::dp_status_type            status,
   output etl_pkg::ctrl_cmd_type             cmd,
   output logic [etl_pkg::ADDR_WIDTH-1:0]    rd_index
);
   import etl_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_LAST = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

   state_type              state_ff;
   state_type              state_in;
   logic [COUNT_WIDTH-1:0] idx_ff;
   logic [COUNT_WIDTH-1:0] idx_in;
   logic [COUNT_WIDTH-1:0] idx_next;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;

   assign idx_next = idx_ff + COUNT_WIDTH'(1);
   assign rd_index = idx_ff[ADDR_WIDTH-1:0];

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      req_ready    = 1'b0;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_type == REQ_LOOKUP) begin
                  cmd.start = 1'b1;
                  idx_in    = '0;
                  if (status.entry_total == '0) begin
                     state_in = ST_DONE;
                  end else begin
                     state_in = ST_SCAN;
                  end
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_SCAN: begin
            cmd.issue = 1'b1;
            idx_in    = idx_next;
            if (idx_next == status.entry_total) begin
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

### hw/rtl/exception_table_lookup.sv
// A lookup scans n table entries after acceptance, where n is the CSR entry count
// capped at the table depth; with n zero it goes straight to the response.
// One lookup runs at a time; one entry is read per cycle while the scan runs.
// A new request is taken while an earlier response still waits in the output register.
// Reset is synchronous and active high; it clears the count and control state only.
// Table contents are not cleared and must be written before they are searched.
module exception_table_lookup (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_type,
   input  logic [etl_pkg::INDEX_WIDTH-1:0]  req_entry_index,
   input  logic [etl_pkg::WORD_WIDTH-1:0]   req_entry_insn,
   input  logic [etl_pkg::WORD_WIDTH-1:0]   req_entry_fixup,
   input  logic [etl_pkg::WORD_WIDTH-1:0]   req_lookup_addr,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_found,
   output logic [etl_pkg::WORD_WIDTH-1:0]   rsp_fixup_addr,
   output logic [etl_pkg::OFFSET_WIDTH-1:0] rsp_range_offset,
   output logic                             rsp_offset_valid,
   input  logic                             csr_we,
   input  logic [etl_pkg::CSR_WIDTH-1:0]    csr_wdata
);
   import etl_pkg::*;

   ctrl_cmd_type            cmd;
   dp_status_type           status;
   logic [ADDR_WIDTH-1:0]   rd_index;

   etl_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_type (req_type),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .status   (status),
      .cmd      (cmd),
      .rd_index (rd_index)
   );

   etl_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .rd_index        (rd_index),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata),
      .req_entry_index (req_entry_index),
      .req_entry_insn  (req_entry_insn),
      .req_entry_fixup (req_entry_fixup),
      .req_lookup_addr (req_lookup_addr),
      .rsp_found       (rsp_found),
      .rsp_fixup_addr  (rsp_fixup_addr),
      .rsp_range_offset(rsp_range_offset),
      .rsp_offset_valid(rsp_offset_valid)
   );

`ifndef SYNTH
   // A range offset is only reported together with a hit.
   a_offset_needs_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_offset_valid |-> rsp_found)
      else $error("offset valid without a match");

   // A miss carries zero fixup and offset.
   a_miss_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_found |-> (rsp_fixup_addr == '0) && (rsp_range_offset == '0))
      else $error("miss beat carries nonzero payload");

   // An accepted lookup keeps the request side closed on the next cycle.
   a_lookup_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_type == REQ_LOOKUP) |=> !req_ready)
      else $error("request accepted during a lookup");

   // Loading a response always presents a beat on the next cycle.
   a_load_shows_beat: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |=> rsp_valid)
      else $error("response load lost");
`endif

endmodule
